[rtl/iidl_pkg.sv]
// ----------------------------------------------------------------------------
// iidl_pkg: shared types and constants of the indexed insert/delete list
// Holds the list capacity, the field widths, the operation and status codes,
// and the command word passed from the front end to the execution engine.
// ----------------------------------------------------------------------------
package iidl_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 7;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_APPEND = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Work the execution engine has to do for one word
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_SHIFT_UP,
        KIND_SHIFT_DN,
        KIND_READ,
        KIND_WRITE
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [ADDR_W-1:0]    pos;    // position operated on
        logic [COUNT_W-1:0]   top;    // element count before the operation
        logic [DATA_W-1:0]    value;  // element to store
        logic [COUNT_W-1:0]   count;  // element count after the operation
        status_t              status;
    } cmd_t;

endpackage

[rtl/iidl_front.sv]
// ----------------------------------------------------------------------------
// iidl_front: operation classifier
// Accepts operation words, tracks the element count, checks the index range
// and capacity, and issues one command word per operation to the queue.
// ----------------------------------------------------------------------------
module iidl_front
    import iidl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_op,
    input  logic [INDEX_W-1:0]   s_index,
    input  logic [DATA_W-1:0]    s_value,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               accept;
    logic               in_range;
    logic               full;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;
    assign in_range  = COUNT_W'(s_index) < count_reg;
    assign full      = count_reg == DEPTH_COUNT;

    // Classify the operation against the current count
    always_comb begin
        cmd.kind   = KIND_NONE;
        cmd.pos    = ADDR_W'(s_index);
        cmd.top    = count_reg;
        cmd.value  = s_value;
        cmd.status = STAT_OK;
        count_next = count_reg;
        unique case (op_t'(s_op))
            OP_INSERT: begin
                if (COUNT_W'(s_index) > count_reg) begin
                    cmd.status = STAT_RANGE;
                end else if (full) begin
                    cmd.status = STAT_FULL;
                end else begin
                    cmd.kind   = KIND_SHIFT_UP;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_APPEND: begin
                cmd.pos = ADDR_W'(count_reg);
                if (full) begin
                    cmd.status = STAT_FULL;
                end else begin
                    cmd.kind   = KIND_SHIFT_UP;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (!in_range) begin
                    cmd.status = STAT_RANGE;
                end else begin
                    cmd.kind   = KIND_SHIFT_DN;
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            OP_READ: begin
                if (!in_range) cmd.status = STAT_RANGE;
                else           cmd.kind   = KIND_READ;
            end
            OP_WRITE: begin
                if (!in_range) cmd.status = STAT_RANGE;
                else           cmd.kind   = KIND_WRITE;
            end
            default: begin
                cmd.kind = KIND_NONE;
            end
        endcase
        cmd.count = count_next;
    end

    // Advance the count on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

endmodule

[rtl/iidl_queue.sv]
// ----------------------------------------------------------------------------
// iidl_queue: two-entry command queue
// Decouples the classifier from the execution engine so each side can
// stall on its own.
// ----------------------------------------------------------------------------
module iidl_queue
    import iidl_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  cmd_t  in_cmd,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  out_cmd
);

    cmd_t        slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        push;
    logic        pop;

    assign in_ready  = fill_reg != 2'd2;
    assign out_valid = fill_reg != 2'd0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Store pushed words
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      fill_reg <= fill_reg + 2'd1;
            else if (pop && !push) fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

[rtl/iidl_engine.sv]
// ----------------------------------------------------------------------------
// iidl_engine: list execution engine
// Owns the element memory, carries out shifts, reads and writes one entry
// per cycle, and holds the result word in an output register.
// ----------------------------------------------------------------------------
module iidl_engine
    import iidl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_read_value,
    output logic [COUNT_W-1:0]   m_count,
    output logic [STAT_W-1:0]    m_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_FINAL,
        S_DN,
        S_RD
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cur_reg, cur_next;
    logic [ADDR_W-1:0]   wptr_reg, wptr_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_read_value_reg, m_read_value_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;
    status_t             m_status_reg, m_status_next;

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   rdata_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    cmd_t                act;
    logic                out_free;
    logic                done;
    logic                done_rd;

    assign out_free     = !m_valid_reg || m_ready;
    assign cmd_ready    = (state_reg == S_IDLE) && out_free;
    assign act          = (state_reg == S_IDLE) ? cmd : cur_reg;
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_count      = m_count_reg;
    assign m_status     = m_status_reg;

    // Sequence the memory accesses of the current command
    always_comb begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        wptr_next         = wptr_reg;
        m_valid_next      = m_valid_reg;
        m_read_value_next = m_read_value_reg;
        m_count_next      = m_count_reg;
        m_status_next     = m_status_reg;
        mem_we            = 1'b0;
        mem_waddr         = wptr_reg;
        mem_wdata         = rdata_reg;
        mem_raddr         = '0;
        done              = 1'b0;
        done_rd           = 1'b0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cur_next = cmd;
                    case (cmd.kind)
                        KIND_SHIFT_UP: begin
                            if (COUNT_W'(cmd.pos) == cmd.top) begin
                                mem_we    = 1'b1;
                                mem_waddr = cmd.pos;
                                mem_wdata = cmd.value;
                                done      = 1'b1;
                            end else begin
                                mem_raddr  = ADDR_W'(cmd.top - COUNT_W'(1));
                                wptr_next  = ADDR_W'(cmd.top);
                                state_next = S_UP;
                            end
                        end
                        KIND_SHIFT_DN: begin
                            if (COUNT_W'(cmd.pos) + COUNT_W'(1) == cmd.top) begin
                                done = 1'b1;
                            end else begin
                                mem_raddr  = cmd.pos + ADDR_W'(1);
                                wptr_next  = cmd.pos;
                                state_next = S_DN;
                            end
                        end
                        KIND_READ: begin
                            mem_raddr  = cmd.pos;
                            state_next = S_RD;
                        end
                        KIND_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = cmd.pos;
                            mem_wdata = cmd.value;
                            done      = 1'b1;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            // Move one entry up per cycle, from the top down to the position
            S_UP: begin
                mem_we = 1'b1;
                if (wptr_reg - ADDR_W'(1) == cur_reg.pos) begin
                    state_next = S_FINAL;
                end else begin
                    mem_raddr = wptr_reg - ADDR_W'(2);
                    wptr_next = wptr_reg - ADDR_W'(1);
                end
            end
            S_FINAL: begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg.pos;
                mem_wdata  = cur_reg.value;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            // Move one entry down per cycle, from the position up to the top
            S_DN: begin
                mem_we = 1'b1;
                if (COUNT_W'(wptr_reg) + COUNT_W'(2) == cur_reg.top) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    mem_raddr = wptr_reg + ADDR_W'(2);
                    wptr_next = wptr_reg + ADDR_W'(1);
                end
            end
            S_RD: begin
                done       = 1'b1;
                done_rd    = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Load the result word on completion
        if (done) begin
            m_valid_next      = 1'b1;
            m_read_value_next = done_rd ? rdata_reg : '0;
            m_count_next      = act.count;
            m_status_next     = act.status;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg          <= cur_next;
        wptr_reg         <= wptr_next;
        m_read_value_reg <= m_read_value_next;
        m_count_reg      <= m_count_next;
        m_status_reg     <= m_status_next;
    end

    // Element memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

[rtl/indexed_insert_delete_list.sv]
// Each command passes the command queue, then the engine. Write, append, insert at the
// end, removal of the last element, errors and unused codes complete when accepted;
// reads wait for the registered memory read; other inserts and removes shift one entry
// per cycle through the single-write-port memory, and the next command waits for them.
// Reset (aresetn, synchronous, active low) clears the count, the queue and
// the output valid; the element memory is not cleared.
// ----------------------------------------------------------------------------
// indexed_insert_delete_list: fixed-capacity ordered list of signed words
// Classifier, two-entry command queue and memory-based execution engine.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list
    import iidl_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [OP_W-1:0]             s_op,
    input  logic [INDEX_W-1:0]          s_index,
    input  logic signed [DATA_W-1:0]    s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DATA_W-1:0]    m_read_value,
    output logic [COUNT_W-1:0]          m_count,
    output logic [STAT_W-1:0]           m_status
);

    cmd_t  front_cmd;
    logic  front_valid;
    logic  front_ready;
    cmd_t  queue_cmd;
    logic  queue_valid;
    logic  queue_ready;

    iidl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_index   (s_index),
        .s_value   (s_value),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    iidl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    iidl_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (queue_valid),
        .cmd_ready    (queue_ready),
        .cmd          (queue_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_count      (m_count),
        .m_status     (m_status)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the indexed insert/delete list
// Drives list operations over the s_ channel and checks every m_ word against
// an in-bench copy of the list, field by field. A short directed run covers
// empty, middle, end and out-of-range cases and the unused codes. Random runs
// then fill the list to capacity and drain it again while both sides stall.
// ----------------------------------------------------------------------------
module tb;
    import iidl_pkg::*;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int RANDOM_ITEMS = 1780;
    localparam int TAIL_ITEMS   = 200;   // final stretch without stalls
    localparam int DRAIN_CYCLES = 80;
    localparam int INDEX_MAX    = DEPTH;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_LAST     = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} phase_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
    } list_result_t;

    // Shadow list plus the queue of results still owed by the block
    class list_scoreboard;
        logic signed [DATA_W-1:0] cells [DEPTH];
        int unsigned              held;
        list_result_t             owed [$];
        int                       errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            held   = 0;
            errors = 0;
        endfunction

        // Apply one accepted word to the shadow list and queue its result
        function void note_word(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                logic signed [DATA_W-1:0] val);
            list_result_t r;
            int unsigned  pos;
            int           j;
            r.read_value = '0;
            r.status     = STAT_OK;
            pos          = idx;
            case (op)
                OP_INSERT, OP_APPEND: begin
                    if (op == OP_APPEND) pos = held;
                    if (pos > held) begin
                        r.status = STAT_RANGE;
                    end else if (held >= DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        for (j = held; j > pos; j--) cells[j] = cells[j-1];
                        cells[pos] = val;
                        held++;
                    end
                end
                OP_REMOVE: begin
                    if (pos >= held) begin
                        r.status = STAT_RANGE;
                    end else begin
                        for (j = pos + 1; j < held; j++) cells[j-1] = cells[j];
                        held--;
                    end
                end
                OP_READ: begin
                    if (pos >= held) r.status = STAT_RANGE;
                    else r.read_value = cells[pos];
                end
                OP_WRITE: begin
                    if (pos >= held) r.status = STAT_RANGE;
                    else cells[pos] = val;
                end
                default: ;
            endcase
            r.count = COUNT_W'(held);
            owed.push_back(r);
        endfunction

        function void miss(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            errors++;
            $error("%s: expected %h, got %h", field, want, got);
        endfunction

        // Compare one result word with the oldest owed result
        function void check_word(logic signed [DATA_W-1:0] rd, logic [COUNT_W-1:0] cnt,
                                 logic [STAT_W-1:0] st);
            list_result_t w;
            if (owed.size() == 0) begin
                errors++;
                $error("result word with no operation waiting");
                return;
            end
            w = owed.pop_front();
            if (rd !== w.read_value) miss("read_value", w.read_value, rd);
            if (cnt !== w.count) miss("count", DATA_W'(w.count), DATA_W'(cnt));
            if (st !== w.status) miss("status", DATA_W'(w.status), DATA_W'(st));
        endfunction
    endclass

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [OP_W-1:0]            s_op    = '0;
    logic [INDEX_W-1:0]         s_index = '0;
    logic signed [DATA_W-1:0]   s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [DATA_W-1:0]   m_read_value;
    logic [COUNT_W-1:0]         m_count;
    logic [STAT_W-1:0]          m_status;

    logic                       quiet = 1'b0;  // no stalls on either side
    list_scoreboard             sb;
    int                         idle_cycles = 0;

    always #5 aclk = ~aclk;

    indexed_insert_delete_list DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_count      (m_count),
        .m_status     (m_status)
    );

    // Present one word and hold it until the block takes it
    task automatic send_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] val);
        s_valid <= 1'b1;
        s_op    <= op;
        s_index <= idx;
        s_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(op, idx, val);
    endtask

    // Empty list, middle and end positions, extremes and unused codes
    task automatic run_directed();
        int k;
        send_word(OP_READ, 0, 0);
        send_word(OP_REMOVE, 0, 0);
        send_word(OP_WRITE, 0, 7);
        send_word(OP_INSERT, 1, 9);
        send_word(OP_APPEND, INDEX_W'(INDEX_MAX), VAL_MAX);
        send_word(OP_INSERT, 0, VAL_MIN);
        send_word(OP_INSERT, 1, -1);
        send_word(OP_INSERT, 3, 0);
        send_word(OP_INSERT, INDEX_W'(INDEX_MAX), 3);
        for (k = 0; k <= 4; k++) send_word(OP_READ, INDEX_W'(k), 0);
        send_word(OP_WRITE, 2, 32'sh5555_5555);
        send_word(OP_WRITE, 4, 1);
        send_word(OP_READ, 2, 0);
        for (k = OP_SPARE_LO; k <= OP_LAST; k++) send_word(OP_W'(k), 1, VAL_MAX);
        send_word(OP_REMOVE, 1, 0);
        send_word(OP_REMOVE, 2, 0);
        send_word(OP_REMOVE, 0, 0);
        send_word(OP_REMOVE, 5, 0);
        send_word(OP_READ, 0, 0);
    endtask

    // Alternate fill-to-full, drain-to-empty and mixed stretches
    task automatic run_random(input int total);
        phase_t                   phase;
        int                       n;
        int                       r;
        int                       c;
        int                       full_hits;
        int                       mixed_left;
        bit                       calm;
        logic [OP_W-1:0]          op;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] val;
        phase      = PH_GROW;
        full_hits  = 0;
        mixed_left = 0;
        for (n = 0; n < total; n++) begin
            calm = (n >= total - TAIL_ITEMS) || (n % 300 < 60);
            quiet <= calm;

            // pick the operation by phase
            c = sb.held;
            r = $urandom_range(0, 99);
            case (phase)
                PH_GROW:
                    op = r < 45 ? OP_INSERT : r < 80 ? OP_APPEND : r < 88 ? OP_READ :
                         r < 94 ? OP_WRITE : r < 97 ? OP_REMOVE : OP_SPARE_LO;
                PH_SHRINK:
                    op = r < 55 ? OP_REMOVE : r < 70 ? OP_READ : r < 80 ? OP_WRITE :
                         r < 88 ? OP_INSERT : r < 94 ? OP_APPEND : OP_SPARE_LO;
                default:
                    op = r < 20 ? OP_INSERT : r < 40 ? OP_REMOVE : r < 60 ? OP_READ :
                         r < 78 ? OP_WRITE : r < 95 ? OP_APPEND : OP_SPARE_LO;
            endcase
            if (op == OP_SPARE_LO) op = OP_W'($urandom_range(OP_SPARE_LO, OP_LAST));

            // mostly legal positions, some anywhere from 0 to DEPTH
            if ($urandom_range(0, 9) == 0)
                idx = INDEX_W'($urandom_range(0, INDEX_MAX));
            else if (op == OP_INSERT)
                idx = INDEX_W'($urandom_range(0, c));
            else
                idx = (c == 0) ? '0 : INDEX_W'($urandom_range(0, c - 1));

            case ($urandom_range(0, 15))
                0: val = VAL_MIN;
                1: val = VAL_MAX;
                2: val = '0;
                3: val = -1;
                default: val = $urandom;
            endcase

            // sender gap
            if (!calm && $urandom_range(0, 7) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            send_word(op, idx, val);

            // advance the phase
            case (phase)
                PH_GROW: begin
                    if (sb.held == DEPTH) full_hits++;
                    if (full_hits >= 4) begin
                        full_hits = 0;
                        phase     = PH_SHRINK;
                    end
                end
                PH_SHRINK: begin
                    if (sb.held == 0) begin
                        mixed_left = 40;
                        phase      = PH_MIXED;
                    end
                end
                default: begin
                    mixed_left--;
                    if (mixed_left <= 0) phase = PH_GROW;
                end
            endcase
        end
        s_valid <= 1'b0;
    endtask

    // Stimulus, drain and verdict
    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random(RANDOM_ITEMS);
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Receiver stalls in random bursts
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Check each result word taken from the block
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_read_value, m_count, m_status);
    end

    // End the run when no word moves on either side for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule

[indexed_insert_delete_list.f]
rtl/iidl_pkg.sv
rtl/iidl_front.sv
rtl/iidl_queue.sv
rtl/iidl_engine.sv
rtl/indexed_insert_delete_list.sv
tb/tb.sv
